### hdl/sacd_pkg.sv
// Shared types and constants for the steering average center detector.
package sacd_pkg;

	localparam int WINDOW_LEN_DEF = 20;

	localparam int SAMPLE_W = 12;
	localparam int TARGET_W = 22;
	localparam int COUNT_W  = 6;
	localparam int CFG_IDX_W = 2;

	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	// register map
	localparam logic [CFG_IDX_W-1:0] CFG_BAND_LOW    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BAND_HIGH   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DWELL_LIMIT = 2'd2;

	localparam logic [SAMPLE_W-1:0] BAND_LOW_RST    = 12'd2010;
	localparam logic [SAMPLE_W-1:0] BAND_HIGH_RST   = 12'd2210;
	localparam logic [COUNT_W-1:0]  DWELL_LIMIT_RST = 6'd18;

	// target = (sample - mid) * scale + offset
	localparam logic signed [SAMPLE_W:0]   SAMPLE_MID    = 13'sd2048;
	localparam logic signed [TARGET_W-1:0] TARGET_SCALE  = 22'sd800;
	localparam logic signed [TARGET_W-1:0] TARGET_OFFSET = 22'sd360000;

	localparam int SAMPLE_MAX = 4095;

endpackage

### hdl/steering_average_center_detect.sv
// Top level of the steering average center detector.
//
// Takes one 12-bit steering sample per transfer and returns one result per
// sample: the boxcar average of the last WINDOW_LEN samples (slots not yet
// written count as zero), a zero request once the average has stayed inside
// [band_low, band_high] for more than dwell_limit consecutive samples, and
// otherwise the target position (sample-2048)*800+360000. The block accepts
// one sample every cycle unless the output stalls; results go through stages
// 1 to 3 and the output register. The rate is set by the sample ring, a RAM
// with one read and one write port: each sample reads its slot on acceptance
// and writes it back from stage 1, together with the running-sum update.
// Slots read as zero until first written, tracked by one valid flop per slot,
// so no clearing pass follows reset. Configuration writes belong in idle time.
module steering_average_center_detect #(
	parameter int WINDOW_LEN = sacd_pkg::WINDOW_LEN_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// s_tdata: [11:0] adc_sample, [15:12] zero
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,
	// m_tdata: [0] zero_request, [22:1] target_position, [34:23] average_value,
	// [39:35] zero
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,
	input  logic        cfg_wr_en,
	input  logic [sacd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [sacd_pkg::SAMPLE_W-1:0]  cfg_wdata
);

	localparam int SW    = sacd_pkg::SAMPLE_W;
	localparam int TW    = sacd_pkg::TARGET_W;
	localparam int CW    = sacd_pkg::COUNT_W;
	localparam int IDX_W = $clog2(WINDOW_LEN);
	localparam int SUM_W = $clog2(WINDOW_LEN * sacd_pkg::SAMPLE_MAX + 1);
	// exact division by reciprocal: floor(sum * RECIP >> SHIFT) == sum / WINDOW_LEN
	localparam int SHIFT  = SUM_W + $clog2(WINDOW_LEN);
	localparam int MUL_W  = SUM_W + 1;
	localparam int PROD_W = SUM_W + MUL_W;
	localparam longint RECIP_L = ((64'd1 << SHIFT) + WINDOW_LEN - 1) / WINDOW_LEN;
	localparam logic [MUL_W-1:0] RECIP = MUL_W'(RECIP_L);
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(WINDOW_LEN - 1);
	localparam logic [SUM_W-1:0] SUM_MAX = SUM_W'(WINDOW_LEN * sacd_pkg::SAMPLE_MAX);

	// configuration
	logic [SW-1:0] band_low_q;
	logic [SW-1:0] band_high_q;
	logic [CW-1:0] dwell_limit_q;

	// ring state
	logic [IDX_W-1:0]      idx_q;
	logic [WINDOW_LEN-1:0] vld_q;
	logic [SUM_W-1:0]      sum_q;
	logic [CW-1:0]         count_q;

	// pipeline
	logic                s1_valid_s1, s2_valid_s2, s3_valid_s3;
	logic [SW-1:0]       sample_s1, sample_s2;
	logic [IDX_W-1:0]    slot_s1;
	logic                hit_s1;
	logic [SUM_W-1:0]    sum_s2;
	logic [PROD_W-1:0]   prod_s3;
	logic signed [TW-1:0] target_s3;

	// output register
	logic                 out_valid_q;
	logic                 out_zero_q;
	logic signed [TW-1:0] out_target_q;
	logic [SW-1:0]        out_avg_q;

	logic                 stall;
	logic                 accept;
	logic                 s1_adv;
	logic [SW-1:0]        ram_rd;
	logic [SW-1:0]        old_sample;
	logic [SUM_W-1:0]     sum_next;
	logic signed [SW:0]   centered;
	logic signed [TW-1:0] target_calc;
	logic [SW-1:0]        avg;
	logic                 in_band;
	logic [CW-1:0]        count_next;
	logic                 zero_next;

	assign stall    = out_valid_q && !m_tready;
	assign s_tready = !stall;
	assign accept   = s_tvalid && !stall;
	assign s1_adv   = s1_valid_s1 && !stall;

	sacd_ram #(
		.DATA_W(SW),
		.DEPTH (WINDOW_LEN)
	) u_ring (
		.clk    (clk),
		.wr_en  (s1_adv),
		.wr_addr(slot_s1),
		.wr_data(sample_s1),
		.rd_en  (accept),
		.rd_addr(idx_q),
		.rd_data(ram_rd)
	);

	// stage 1: retire the oldest sample, update the running sum
	assign old_sample = hit_s1 ? ram_rd : '0;
	assign sum_next   = sum_q + SUM_W'(sample_s1) - SUM_W'(old_sample);

	// stage 2: target position
	assign centered    = $signed({1'b0, sample_s2}) - sacd_pkg::SAMPLE_MID;
	assign target_calc = TW'(centered) * sacd_pkg::TARGET_SCALE + sacd_pkg::TARGET_OFFSET;

	// stage 3: average, band check, dwell count
	assign avg     = prod_s3[SHIFT +: SW];
	assign in_band = (avg >= band_low_q) && (avg <= band_high_q);

	always_comb begin
		if (!in_band) begin
			count_next = '0;
		end else if (count_q == sacd_pkg::COUNT_MAX) begin
			count_next = count_q;
		end else begin
			count_next = count_q + CW'(1);
		end
	end

	assign zero_next = count_next > dwell_limit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			band_low_q    <= sacd_pkg::BAND_LOW_RST;
			band_high_q   <= sacd_pkg::BAND_HIGH_RST;
			dwell_limit_q <= sacd_pkg::DWELL_LIMIT_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				sacd_pkg::CFG_BAND_LOW:    band_low_q    <= cfg_wdata;
				sacd_pkg::CFG_BAND_HIGH:   band_high_q   <= cfg_wdata;
				sacd_pkg::CFG_DWELL_LIMIT: dwell_limit_q <= cfg_wdata[CW-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			vld_q       <= '0;
			sum_q       <= '0;
			count_q     <= '0;
			s1_valid_s1 <= 1'b0;
			s2_valid_s2 <= 1'b0;
			s3_valid_s3 <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (!stall) begin
			s1_valid_s1 <= s_tvalid;
			s2_valid_s2 <= s1_valid_s1;
			s3_valid_s3 <= s2_valid_s2;
			out_valid_q <= s3_valid_s3;
			if (s_tvalid) begin
				idx_q <= (idx_q == IDX_LAST) ? '0 : idx_q + IDX_W'(1);
			end
			if (s1_valid_s1) begin
				sum_q          <= sum_next;
				vld_q[slot_s1] <= 1'b1;
			end
			if (s3_valid_s3) begin
				count_q <= count_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!stall) begin
			sample_s1    <= s_tdata[SW-1:0];
			slot_s1      <= idx_q;
			hit_s1       <= vld_q[idx_q];
			sample_s2    <= sample_s1;
			sum_s2       <= sum_next;
			prod_s3      <= PROD_W'(sum_s2) * PROD_W'(RECIP);
			target_s3    <= target_calc;
			out_zero_q   <= zero_next;
			out_target_q <= zero_next ? '0 : target_s3;
			out_avg_q    <= avg;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {5'd0, out_avg_q, out_target_q, out_zero_q};

	// write-back slot never collides with the slot read in the same cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		(s1_adv && accept) |-> (slot_s1 != idx_q))
		else $error("ring read and write hit the same slot");

	assert property (@(posedge clk) disable iff (!arst_n)
		sum_q <= SUM_MAX)
		else $error("running sum exceeds window capacity");

	assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= IDX_LAST)
		else $error("ring index out of range");

	// a stalled output must not let the dwell count or the running sum move
	assert property (@(posedge clk) disable iff (!arst_n)
		stall |=> $stable(count_q) && $stable(sum_q))
		else $error("state advanced during output stall");

endmodule

### hdl/sacd_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sacd_ram #(
	parameter int DATA_W = 12,
	parameter int DEPTH  = 20
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [DATA_W-1:0]        wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [DATA_W-1:0]        rd_data
);

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule
